FILE: hdl/kmpt_pkg.sv
`timescale 1ns / 1ps

package kmpt_pkg;

	localparam int BOARD_SIZE = 8;
	localparam int CELLS      = BOARD_SIZE * BOARD_SIZE;
	localparam int CELL_W     = $clog2(CELLS);
	localparam int COORD_W    = $clog2(BOARD_SIZE);
	localparam int LINE_W     = 16;
	localparam int HALF       = 4;
	localparam int TIME_W     = 31;
	localparam int ELAPSED_W  = 32;
	localparam int CFG_W      = 16;
	localparam int REG_IDX_W  = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_PRESS_THRESHOLD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE_HOLD    = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	// Settings that the cell updater needs for the whole frame.
	typedef struct packed {
		logic [CFG_W:0]         clamp;
		logic [ELAPSED_W-1:0]   elapsed;
	} upd_ctl_t;

	// Spreads the four serial words over the row-major cell vector.
	function automatic logic [CELLS-1:0] map_pressed(
		input logic [LINE_W-1:0] l0,
		input logic [LINE_W-1:0] l1,
		input logic [LINE_W-1:0] l2,
		input logic [LINE_W-1:0] l3
	);
		logic [CELLS-1:0] p;
		int r;
		int c;
		p = '0;
		for (int i = 0; i < LINE_W; i++) begin
			r = i / HALF;
			c = i % HALF;
			p[r * BOARD_SIZE + c]                                        = l0[i];
			p[r * BOARD_SIZE + c + HALF]                                 = l1[i];
			p[(BOARD_SIZE - 1 - r) * BOARD_SIZE + (HALF - 1 - c)]       = l2[i];
			p[(BOARD_SIZE - 1 - r) * BOARD_SIZE + (BOARD_SIZE - 1 - c)] = l3[i];
		end
		return p;
	endfunction

endpackage

FILE: hdl/kmpt_if.sv
`timescale 1ns / 1ps

interface kmpt_frame_if import kmpt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [LINE_W-1:0]    line0_bits;
	logic [LINE_W-1:0]    line1_bits;
	logic [LINE_W-1:0]    line2_bits;
	logic [LINE_W-1:0]    line3_bits;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, line0_bits, line1_bits, line2_bits, line3_bits, elapsed_ms,
		input ready);
	modport sink (input valid, line0_bits, line1_bits, line2_bits, line3_bits, elapsed_ms,
		output ready);
endinterface

interface kmpt_result_if import kmpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [COORD_W-1:0] best_row;
	logic [COORD_W-1:0] best_col;
	logic [TIME_W-1:0]  best_time;

	modport source (output valid, found, best_row, best_col, best_time, input ready);
	modport sink (input valid, found, best_row, best_col, best_time, output ready);
endinterface

FILE: hdl/key_matrix_press_timer_top.sv
`timescale 1ns / 1ps

// Press timer for an 8x8 key matrix. Each frame word holds the four serial data
// lines and the milliseconds since the previous frame; the block updates the
// press time of all 64 cells and returns one word with the longest-held cell
// whose time exceeds the press threshold. The 64 press times live in a
// single-port-write, registered-read memory and are walked by one shared cell
// updater, one cell per cycle; after acceptance the block reads all 64 cells,
// drains the pipeline, loads the output register and returns to idle, where
// the next frame can be accepted. The frame port is not ready while a walk is
// in progress, and a finished frame waits before the output load while an
// earlier result word is still held, which stretches the frame by that stall.
// Configuration registers (press threshold, release hold) are written through
// cfg_we, cfg_idx and cfg_data; a write to an unknown index is ignored.
module key_matrix_press_timer_top import kmpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	kmpt_frame_if.sink           frame,
	kmpt_result_if.source        result
);

	state_t state_q;
	state_t state_d;

	logic [CFG_W-1:0]     thr_q;
	logic [CFG_W-1:0]     hold_q;
	logic [CELLS-1:0]     pressed_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [CELL_W-1:0]    rd_k_q;
	logic [CELLS-1:0]     vld_q;
	logic [TIME_W-1:0]    mem [CELLS];

	logic                 v_s1;
	logic [CELL_W-1:0]    addr_s1;
	logic [TIME_W-1:0]    rdata_s1;

	logic [TIME_W-1:0]    best_q;
	logic [CELL_W-1:0]    best_k_q;
	logic                 found_q;

	logic                 out_valid_q;
	logic                 out_found_q;
	logic [CELL_W-1:0]    out_k_q;
	logic [TIME_W-1:0]    out_time_q;

	logic                 accept;
	logic                 load_out;
	logic                 walk_done;
	upd_ctl_t             ctl;
	logic [TIME_W-1:0]    time_old;
	logic [TIME_W-1:0]    time_new;
	logic                 better;

	assign accept    = frame.valid && frame.ready;
	assign walk_done = (rd_k_q == CELL_W'(CELLS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (frame.valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_done) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_valid_q || result.ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		frame.ready = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				frame.ready = 1'b1;
			end
			ST_HOLD: begin
				load_out = !out_valid_q || result.ready;
			end
			default: begin
				frame.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= CFG_W'(300);
			hold_q <= CFG_W'(200);
		end else if (cfg_we) begin
			if (cfg_idx == REG_PRESS_THRESHOLD) thr_q <= cfg_data;
			if (cfg_idx == REG_RELEASE_HOLD) hold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pressed_q <= map_pressed(frame.line0_bits, frame.line1_bits,
				frame.line2_bits, frame.line3_bits);
			elapsed_q <= frame.elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_k_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				rd_k_q <= '0;
			end else if (state_q == ST_WALK) begin
				rd_k_q <= rd_k_q + 1'b1;
			end
			v_s1 <= (state_q == ST_WALK);
		end
	end

	// Registered read of the next cell while the previous one is written back.
	always_ff @(posedge clk) begin
		addr_s1  <= rd_k_q;
		rdata_s1 <= mem[rd_k_q];
		if (v_s1) begin
			mem[addr_s1] <= time_new;
		end
	end

	// A cell that was never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (v_s1) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	assign time_old = vld_q[addr_s1] ? rdata_s1 : '0;
	assign ctl      = {({1'b0, thr_q} + {1'b0, hold_q}), elapsed_q};

	kmpt_cell_update u_update (
		.ctl      (ctl),
		.pressed  (pressed_q[addr_s1]),
		.time_old (time_old),
		.time_new (time_new)
	);

	// Strictly greater keeps the earliest cell in row-major order on a tie.
	assign better = (time_new > {{(TIME_W-CFG_W){1'b0}}, thr_q}) && (time_new > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			best_k_q <= '0;
			found_q  <= 1'b0;
		end else if (accept) begin
			best_q   <= '0;
			best_k_q <= '0;
			found_q  <= 1'b0;
		end else if (v_s1 && better) begin
			best_q   <= time_new;
			best_k_q <= addr_s1;
			found_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_k_q     <= '0;
			out_time_q  <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_found_q <= found_q;
			out_k_q     <= best_k_q;
			out_time_q  <= best_q;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.found     = out_found_q;
	assign result.best_row  = out_k_q[CELL_W-1:COORD_W];
	assign result.best_col  = out_k_q[COORD_W-1:0];
	assign result.best_time = out_time_q;

	a_walk_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && !walk_done) |=> (rd_k_q == $past(rd_k_q) + 1'b1))
		else $error("cell counter skipped during walk");

	a_pipe_only_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ($past(state_q) == ST_WALK))
		else $error("cell update outside of a walk");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |->
		(result.best_time == '0 && result.best_row == '0 && result.best_col == '0))
		else $error("result fields nonzero without a found cell");

	a_found_above_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.found) |->
		(result.best_time > {{(TIME_W-CFG_W){1'b0}}, thr_q}))
		else $error("reported time not above press threshold");

endmodule

FILE: hdl/kmpt_cell_update.sv
`timescale 1ns / 1ps

module kmpt_cell_update import kmpt_pkg::*; (
	input  upd_ctl_t          ctl,
	input  logic              pressed,
	input  logic [TIME_W-1:0] time_old,
	output logic [TIME_W-1:0] time_new
);

	logic [TIME_W+1:0] sum;
	logic [TIME_W-1:0] clamped;
	logic [TIME_W-1:0] clamp_ext;

	assign clamp_ext = {{(TIME_W-CFG_W-1){1'b0}}, ctl.clamp};
	assign sum       = {2'b00, time_old} + {1'b0, ctl.elapsed};
	assign clamped   = (time_old > clamp_ext) ? clamp_ext : time_old;

	// A released cell at zero fails the decrement test and stays zero.
	always_comb begin
		if (pressed) begin
			time_new = (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
		end else if (ctl.elapsed < {1'b0, clamped}) begin
			time_new = clamped - ctl.elapsed[TIME_W-1:0];
		end else begin
			time_new = '0;
		end
	end

endmodule
